@@ hw/rtl/dtq_pkg.sv @@
// Shared types and codes of the delta timer queue.
package dtq_pkg;

   localparam int ID_W    = 16;
   localparam int DELTA_W = 32;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_POP    = 2'd2;

   localparam status_type STATUS_DONE      = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;
   localparam status_type STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [DELTA_W-1:0] delta;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ hw/rtl/dtq_if.sv @@
// Request and response channel interfaces of the delta timer queue.
interface dtq_req_if
   import dtq_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   cmd_type              command;
   logic [ID_W-1:0]      task_id;
   logic [DELTA_W-1:0]   delay_in;

   modport source (output valid, command, task_id, delay_in, input ready);
   modport sink   (input valid, command, task_id, delay_in, output ready);
endinterface

interface dtq_rsp_if
   import dtq_pkg::*;
   #(parameter int CNT_W = 5)
   ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [ID_W-1:0]      out_id;
   logic [DELTA_W-1:0]   out_delta;
   logic [CNT_W-1:0]     entry_count;

   modport source (output valid, status, out_id, out_delta, entry_count, input ready);
   modport sink   (input valid, status, out_id, out_delta, entry_count, output ready);
endinterface

@@ hw/rtl/dtq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/delta_timer_queue.sv @@
// Delta timer queue: a bounded list of up to CAPACITY timers kept in order of expiry, where
// each entry stores a task id and its delay relative to the entry ahead of it. An insert
// walks the list from the front one entry per cycle, since each step needs the link and
// delta read out of the slot memories before the next address is known. An insert takes a
// free slot, walks the entries it must examine (at most CAPACITY), then links the new entry
// in and fixes up its neighbours. A remove that finds its id walks, passes its delta on to
// its successor and frees its slot; one that does not only walks. A pop unlinks the head
// directly, and a request refused as full or empty, or a remove on an empty queue, goes
// straight to loading its result into the response register, which holds a finished
// result while the next request is taken; a result that finds the register still occupied
// waits until the consumer drains it. After reset the queue is empty and ready at once.
module delta_timer_queue
   import dtq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic     clock,
   input  logic     reset,
   dtq_req_if.sink  req_bus,
   dtq_rsp_if.source rsp_bus
);

   localparam int SW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam logic [LW-1:0] NIL = LW'(CAPACITY);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_ALLOC    = 9'b000000010,
      ST_WALK     = 9'b000000100,
      ST_INS_LINK = 9'b000001000,
      ST_INS_FIX  = 9'b000010000,
      ST_REM_ADD  = 9'b000100000,
      ST_REM_FREE = 9'b001000000,
      ST_POP      = 9'b010000000,
      ST_RESP     = 9'b100000000
   } state_type;

   // Control state.
   state_type          state_ff, state_in;
   logic [LW-1:0]      first_ff, first_in;
   logic [LW-1:0]      free_ff, free_in;
   logic [LW-1:0]      count_ff, count_in;
   logic [CAPACITY-1:0] vld_ff, vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-operation working registers.
   cmd_type            cmd_ff, cmd_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [DELTA_W-1:0] delay_ff, delay_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [LW-1:0]      prev_ff, prev_in;
   logic [LW-1:0]      cur_ff, cur_in;
   logic [LW-1:0]      nxt_ff, nxt_in;
   logic [DELTA_W-1:0] acc_ff, acc_in;
   entry_type          cur_word_ff, cur_word_in;
   logic [SW-1:0]      rd_addr_ff;
   status_type         res_status_ff, res_status_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;
   logic [DELTA_W-1:0] res_delta_ff, res_delta_in;

   // Response register payload.
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [DELTA_W-1:0] rsp_delta_ff, rsp_delta_in;
   logic [LW-1:0]      rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic [SW-1:0]      rd_addr;
   logic               link_we;
   logic [SW-1:0]      link_wa;
   logic [LW-1:0]      link_wd;
   logic [LW-1:0]      link_rd;
   logic               data_we;
   logic [SW-1:0]      data_wa;
   entry_type          data_wd;
   logic [ENTRY_W-1:0] data_rd;

   logic [LW-1:0]      link_q;
   entry_type          data_q;
   logic [DELTA_W:0]   walk_sum;
   logic               req_accept;

   dtq_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   dtq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_wa),
      .wr_data (data_wd),
      .rd_addr (rd_addr),
      .rd_data (data_rd)
   );

   // A link slot never written still holds its place in the initial free chain.
   assign link_q = vld_ff[rd_addr_ff] ? link_rd : (LW'(rd_addr_ff) + LW'(1));
   assign data_q = entry_type'(data_rd);
   assign walk_sum = {1'b0, acc_ff} + {1'b0, data_q.delta};

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.out_id      = rsp_id_ff;
   assign rsp_bus.out_delta   = rsp_delta_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      vld_in        = vld_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      delay_in      = delay_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      acc_in        = acc_ff;
      cur_word_in   = cur_word_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_delta_in  = res_delta_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_delta_in  = rsp_delta_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      rd_addr = first_ff[SW-1:0];
      link_we = 1'b0;
      link_wa = '0;
      link_wd = '0;
      data_we = 1'b0;
      data_wa = '0;
      data_wd = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.command == CMD_INSERT) begin
               rd_addr = free_ff[SW-1:0];
            end
            if (req_accept) begin
               cmd_in   = req_bus.command;
               id_in    = req_bus.task_id;
               delay_in = req_bus.delay_in;
               slot_in  = free_ff[SW-1:0];
               prev_in  = NIL;
               cur_in   = first_ff;
               acc_in   = '0;
               case (req_bus.command)
                  CMD_INSERT: begin
                     if (count_ff >= NIL || free_ff == NIL) begin
                        res_status_in = STATUS_FULL;
                        res_id_in     = req_bus.task_id;
                        res_delta_in  = '0;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_ALLOC;
                     end
                  end
                  CMD_REMOVE: begin
                     if (first_ff == NIL) begin
                        res_status_in = STATUS_NOT_FOUND;
                        res_id_in     = req_bus.task_id;
                        res_delta_in  = '0;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_POP: begin
                     if (first_ff == NIL || count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                        res_id_in     = '0;
                        res_delta_in  = '0;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_DONE;
                     res_id_in     = '0;
                     res_delta_in  = '0;
                     state_in      = ST_RESP;
                  end
               endcase
            end
         end

         ST_ALLOC: begin
            // The allocated slot's link names the new head of the free list.
            free_in = link_q;
            if (first_ff != NIL) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_INS_LINK;
            end
         end

         ST_WALK: begin
            // The next read goes out to the successor while this entry is judged.
            rd_addr = link_q[SW-1:0];
            if (cmd_ff == CMD_INSERT) begin
               if (walk_sum <= {1'b0, delay_ff}) begin
                  acc_in  = walk_sum[DELTA_W-1:0];
                  prev_in = cur_ff;
                  cur_in  = link_q;
                  if (link_q == NIL) begin
                     state_in = ST_INS_LINK;
                  end
               end else begin
                  cur_word_in = data_q;
                  state_in    = ST_INS_LINK;
               end
            end else begin
               if (data_q.id == id_ff) begin
                  cur_word_in = data_q;
                  nxt_in      = link_q;
                  state_in    = ST_REM_ADD;
               end else begin
                  prev_in = cur_ff;
                  cur_in  = link_q;
                  if (link_q == NIL) begin
                     res_status_in = STATUS_NOT_FOUND;
                     res_id_in     = id_ff;
                     res_delta_in  = '0;
                     state_in      = ST_RESP;
                  end
               end
            end
         end

         ST_INS_LINK: begin
            res_status_in = STATUS_DONE;
            res_id_in     = id_ff;
            res_delta_in  = delay_ff - acc_ff;
            data_we       = 1'b1;
            data_wa       = slot_ff;
            data_wd.id    = id_ff;
            data_wd.delta = delay_ff - acc_ff;
            link_we       = 1'b1;
            link_wa       = slot_ff;
            link_wd       = cur_ff;
            vld_in[slot_ff] = 1'b1;
            state_in      = ST_INS_FIX;
         end

         ST_INS_FIX: begin
            if (prev_ff != NIL) begin
               link_we = 1'b1;
               link_wa = prev_ff[SW-1:0];
               link_wd = LW'(slot_ff);
               vld_in[prev_ff[SW-1:0]] = 1'b1;
            end else begin
               first_in = LW'(slot_ff);
            end
            if (cur_ff != NIL) begin
               data_we       = 1'b1;
               data_wa       = cur_ff[SW-1:0];
               data_wd.id    = cur_word_ff.id;
               data_wd.delta = cur_word_ff.delta - res_delta_ff;
            end
            count_in = count_ff + LW'(1);
            state_in = ST_RESP;
         end

         ST_REM_ADD: begin
            // The removed entry's delta passes on to its successor.
            if (nxt_ff != NIL) begin
               data_we       = 1'b1;
               data_wa       = nxt_ff[SW-1:0];
               data_wd.id    = data_q.id;
               data_wd.delta = data_q.delta + cur_word_ff.delta;
            end
            if (prev_ff != NIL) begin
               link_we = 1'b1;
               link_wa = prev_ff[SW-1:0];
               link_wd = nxt_ff;
               vld_in[prev_ff[SW-1:0]] = 1'b1;
            end else begin
               first_in = nxt_ff;
            end
            state_in = ST_REM_FREE;
         end

         ST_REM_FREE: begin
            link_we = 1'b1;
            link_wa = cur_ff[SW-1:0];
            link_wd = free_ff;
            vld_in[cur_ff[SW-1:0]] = 1'b1;
            free_in = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - LW'(1);
            end
            res_status_in = STATUS_DONE;
            res_id_in     = id_ff;
            res_delta_in  = cur_word_ff.delta;
            state_in      = ST_RESP;
         end

         ST_POP: begin
            first_in = link_q;
            link_we  = 1'b1;
            link_wa  = first_ff[SW-1:0];
            link_wd  = free_ff;
            vld_in[first_ff[SW-1:0]] = 1'b1;
            free_in  = first_ff;
            count_in = count_ff - LW'(1);
            res_status_in = STATUS_DONE;
            res_id_in     = data_q.id;
            res_delta_in  = data_q.delta;
            state_in      = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_delta_in  = res_delta_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= NIL;
         free_ff      <= '0;
         count_ff     <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      delay_ff      <= delay_in;
      slot_ff       <= slot_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      acc_ff        <= acc_in;
      cur_word_ff   <= cur_word_in;
      rd_addr_ff    <= rd_addr;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_delta_ff  <= res_delta_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_delta_ff  <= rsp_delta_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
